// ===== design/tpa_pkg.sv =====
// Package holding the types and constants shared by the tropical polynomial evaluator.
package tpa_pkg;

    localparam int IDX_W   = 8;
    localparam int VAL_W   = 24;
    localparam int COUNT_W = 5;

    typedef enum logic {
        FUNC_LOAD = 1'b0,
        FUNC_EVAL = 1'b1
    } tpa_func_t;

    typedef enum logic {
        REG_TERM_COUNT = 1'b0,
        REG_NONE       = 1'b1
    } tpa_reg_t;

    typedef struct packed {
        tpa_func_t          func;
        logic [3:0]         term_index;
        logic signed [15:0] coeff;
        logic [3:0]         exp_x;
        logic [3:0]         exp_y;
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
    } tpa_in_t;

    typedef struct packed {
        logic [3:0]              best_term;
        logic signed [VAL_W-1:0] best_value;
        logic                    empty_res;
    } tpa_out_t;

    typedef struct packed {
        logic signed [15:0] coeff;
        logic [3:0]         exp_x;
        logic [3:0]         exp_y;
    } tpa_term_t;

    typedef struct packed {
        logic                    valid;
        logic                    have;
        logic signed [15:0]      x;
        logic signed [15:0]      y;
        logic signed [VAL_W-1:0] best_val;
        logic [IDX_W-1:0]        best_idx;
    } tpa_tok_t;

endpackage

// ===== design/tpa_cell.sv =====
// One cell of the chain: holds one term and updates the running maximum of a passing request.
module tpa_cell
    import tpa_pkg::*;
#(
    parameter int CELL_IDX = 0
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               adv,
    input  logic               wr_en,
    input  tpa_term_t          wr_term,
    input  logic [COUNT_W-1:0] term_count,
    input  tpa_tok_t           tok_in,
    output tpa_tok_t           tok_out
);

    tpa_term_t               term_reg;
    tpa_tok_t                tok_reg;
    tpa_tok_t                tok_next;
    logic signed [VAL_W-1:0] px;
    logic signed [VAL_W-1:0] py;
    logic signed [VAL_W-1:0] val;
    logic                    active;
    logic                    take;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            term_reg <= wr_term;
        end
    end

    always_comb begin
        px     = VAL_W'($signed({1'b0, term_reg.exp_x})) * VAL_W'(tok_in.x);
        py     = VAL_W'($signed({1'b0, term_reg.exp_y})) * VAL_W'(tok_in.y);
        val    = VAL_W'($signed(term_reg.coeff)) + px + py;
        active = 32'(term_count) > 32'(CELL_IDX);
        take   = tok_in.valid && active && (!tok_in.have || (val > tok_in.best_val));
        tok_next = tok_in;
        if (take) begin
            tok_next.have     = 1'b1;
            tok_next.best_val = val;
            tok_next.best_idx = IDX_W'(CELL_IDX);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
        end else if (adv) begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ===== design/tropical_poly_argmax.sv =====
// Top level of the max-plus polynomial evaluator: channels, register port and cell chain.
// The request channel (s_valid, s_ready, s_req) carries two kinds of request. A load writes one
// term (coefficient and exponents of x and y) into the cell selected by term_index; an evaluate
// brings a point and produces one result on the m_ channel: the greatest term value over the
// first term_count terms and the lowest index that reaches it, or empty_res when no term takes
// part. Loads produce no result.
// Each term lives in its own cell of a chain of MAX_TERMS cells. An evaluate request moves one
// cell per cycle while the chain is not stalled, and its result then enters the output register.
// Evaluates may follow one another in consecutive cycles, one per cycle, while no stall holds
// the chain. A load is accepted only when no evaluate is in the chain, since it would alter
// terms an earlier point has yet to reach; a load therefore waits until the last evaluate has
// left the cell registers, and longer while the receiver stalls.
// The result sits in an output register. While the receiver holds m_ready low with a result
// waiting, the whole chain stands still and s_ready drops for evaluates.
// term_count is written through the APB port at byte address 0 and is read back there; the user
// must write it only while the block is idle, which the block does not enforce. Reset clears
// term_count, the chain and the output; the term table itself must be loaded before it is used.
module tropical_poly_argmax
    import tpa_pkg::*;
#(
    parameter int MAX_TERMS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  tpa_in_t     s_req,
    output logic        m_valid,
    input  logic        m_ready,
    output tpa_out_t    m_res
);

    logic [COUNT_W-1:0] term_count_reg;
    logic               m_valid_reg;
    tpa_out_t           m_res_reg;
    tpa_tok_t           tok [MAX_TERMS+1];
    logic [MAX_TERMS-1:0] busy_vec;
    logic               busy;
    logic               adv;
    logic               accept;
    tpa_term_t          wr_term;
    tpa_reg_t           reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = tpa_reg_t'(paddr[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            term_count_reg <= '0;
        end else if (psel && penable && pwrite && (reg_sel == REG_TERM_COUNT)) begin
            term_count_reg <= pwdata[COUNT_W-1:0];
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_TERM_COUNT: prdata = 32'(term_count_reg);
            default:        prdata = '0;
        endcase
    end

    assign busy = |busy_vec;
    assign adv  = !m_valid_reg || m_ready;

    always_comb begin
        unique case (s_req.func)
            FUNC_EVAL: s_ready = adv;
            default:   s_ready = !busy;
        endcase
    end

    assign accept = s_valid && s_ready;

    always_comb begin
        wr_term.coeff = s_req.coeff;
        wr_term.exp_x = s_req.exp_x;
        wr_term.exp_y = s_req.exp_y;
        tok[0].valid    = accept && (s_req.func == FUNC_EVAL);
        tok[0].have     = 1'b0;
        tok[0].x        = s_req.point_x;
        tok[0].y        = s_req.point_y;
        tok[0].best_val = '0;
        tok[0].best_idx = '0;
    end

    for (genvar i = 0; i < MAX_TERMS; i++) begin : g_cell
        logic wr_en;
        assign wr_en = accept && (s_req.func == FUNC_LOAD)
                       && (32'(s_req.term_index) == 32'(i));
        tpa_cell #(
            .CELL_IDX (i)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .adv        (adv),
            .wr_en      (wr_en),
            .wr_term    (wr_term),
            .term_count (term_count_reg),
            .tok_in     (tok[i]),
            .tok_out    (tok[i+1])
        );
        assign busy_vec[i] = tok[i+1].valid;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= tok[MAX_TERMS].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_res_reg.best_term  <= tok[MAX_TERMS].best_idx[3:0];
            m_res_reg.best_value <= tok[MAX_TERMS].best_val;
            m_res_reg.empty_res  <= !tok[MAX_TERMS].have;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_res   = m_res_reg;

`ifndef ASSERT_OFF
    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_req.func == FUNC_LOAD)) |-> !busy)
        else $error("load accepted while an evaluate is in the chain");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_res.empty_res) |-> ((m_res.best_value == '0) && (m_res.best_term == '0)))
        else $error("empty result carries a non-zero value or index");

    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(tok[MAX_TERMS].valid))
        else $error("result appeared without a request leaving the chain");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready && tok[MAX_TERMS].valid) |=> tok[MAX_TERMS].valid)
        else $error("request dropped from the chain during a stall");
`endif

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the max-plus polynomial evaluator tropical_poly_argmax.
`timescale 1ns / 100ps

module testbench
    import tpa_pkg::*;
();

    localparam int TERM_SLOTS = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [2:0] ADDR_TERM_COUNT = 3'(4 * int'(REG_TERM_COUNT));
    localparam logic [2:0] ADDR_NONE = 3'(4 * int'(REG_NONE));

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    tpa_in_t     s_req = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    tpa_out_t    m_res;

    tpa_in_t  pending_reqs[$];
    tpa_out_t expected_results[$];

    logic signed [15:0] coeff_store [TERM_SLOTS];
    logic [3:0]         exp_x_store [TERM_SLOTS];
    logic [3:0]         exp_y_store [TERM_SLOTS];
    logic [4:0]         term_limit = '0;

    int err_count = 0;
    int cycle_count = 0;
    int send_gap = 0;
    int recv_stall = 0;
    bit send_calm = 1'b0;
    bit recv_calm = 1'b0;
    tpa_out_t want_res;

    tropical_poly_argmax #(.MAX_TERMS(TERM_SLOTS)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_req(s_req),
        .m_valid(m_valid), .m_ready(m_ready), .m_res(m_res)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    task automatic apply_request(input tpa_in_t r);
        tpa_out_t res;
        int n;
        int v;
        int best_v;
        if (r.func == FUNC_LOAD) begin
            coeff_store[r.term_index] = r.coeff;
            exp_x_store[r.term_index] = r.exp_x;
            exp_y_store[r.term_index] = r.exp_y;
        end else begin
            res = '0;
            best_v = 0;
            n = (term_limit > TERM_SLOTS) ? TERM_SLOTS : int'(term_limit);
            if (n == 0) begin
                res.empty_res = 1'b1;
            end else begin
                for (int i = 0; i < n; i++) begin
                    v = int'(coeff_store[i]) + int'(exp_x_store[i]) * int'(r.point_x)
                        + int'(exp_y_store[i]) * int'(r.point_y);
                    if (i == 0 || v > best_v) begin
                        best_v = v;
                        res.best_term = 4'(i);
                    end
                end
                res.best_value = best_v[VAL_W-1:0];
            end
            expected_results.push_back(res);
        end
    endtask

    function automatic logic signed [15:0] extreme_q();
        case ($urandom_range(0, 3))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            default: return 16'shFFFF;
        endcase
    endfunction

    function automatic logic signed [15:0] small_q();
        return 16'((int'($urandom_range(0, 4)) - 2) * 256);
    endfunction

    function automatic tpa_in_t random_request();
        logic [63:0] raw;
        tpa_in_t r;
        raw = {$urandom(), $urandom()};
        r = raw[$bits(tpa_in_t)-1:0];
        r.func = ($urandom_range(0, 3) == 0) ? FUNC_LOAD : FUNC_EVAL;
        case ($urandom_range(0, 5))
            0: begin
                r.coeff = extreme_q();
                r.point_x = extreme_q();
                r.point_y = extreme_q();
            end
            1: begin
                r.coeff = small_q();
                r.exp_x = 4'($urandom_range(0, 2));
                r.exp_y = 4'($urandom_range(0, 2));
                r.point_x = small_q();
                r.point_y = small_q();
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic push_load(input int slot, input logic signed [15:0] c,
                             input logic [3:0] ex, input logic [3:0] ey);
        tpa_in_t r;
        r = '0;
        r.func = FUNC_LOAD;
        r.term_index = 4'(slot);
        r.coeff = c;
        r.exp_x = ex;
        r.exp_y = ey;
        pending_reqs.push_back(r);
    endtask

    task automatic push_eval(input logic signed [15:0] x, input logic signed [15:0] y);
        tpa_in_t r;
        r = '0;
        r.func = FUNC_EVAL;
        r.point_x = x;
        r.point_y = y;
        pending_reqs.push_back(r);
    endtask

    task automatic wait_idle();
        do @(negedge aclk);
        while (pending_reqs.size() != 0 || s_valid || expected_results.size() != 0);
        repeat (TERM_SLOTS + 4) @(negedge aclk);
    endtask

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_TERM_COUNT) begin
            term_limit = data[4:0];
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                apply_request(s_req);
                if ($urandom_range(0, 39) == 0) begin
                    send_calm = !send_calm;
                end
                send_gap = send_calm ? 0 : $urandom_range(0, 13);
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    s_req <= pending_reqs.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %h", $time, m_res);
                    err_count++;
                end else begin
                    want_res = expected_results.pop_front();
                    if (m_res.best_term !== want_res.best_term) begin
                        $display("%0t: best_term expected %0d, got %0d", $time,
                                 want_res.best_term, m_res.best_term);
                        err_count++;
                    end
                    if (m_res.best_value !== want_res.best_value) begin
                        $display("%0t: best_value expected %0d, got %0d", $time,
                                 want_res.best_value, m_res.best_value);
                        err_count++;
                    end
                    if (m_res.empty_res !== want_res.empty_res) begin
                        $display("%0t: empty_res expected %0b, got %0b", $time,
                                 want_res.empty_res, m_res.empty_res);
                        err_count++;
                    end
                end
                if ($urandom_range(0, 39) == 0) begin
                    recv_calm = !recv_calm;
                end
                recv_stall = recv_calm ? 0 : $urandom_range(0, 13);
            end
            if (recv_stall > 0) begin
                recv_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int phase_counts[9];
        int drain;
        phase_counts = '{1, 0, 16, 7, 17, 2, 16, 31, 12};

        // With no terms taking part the result is flagged empty.
        push_eval(16'sh7FFF, 16'sh8000);
        push_eval(16'sh8000, 16'sh7FFF);

        // Slots 1 and 3 share the largest coefficient so that ties arise.
        for (int i = 0; i < TERM_SLOTS; i++) begin
            if (i == 0) begin
                push_load(i, 16'sh8000, 4'(i), 4'(15 - i));
            end else if (i == 1 || i == 3) begin
                push_load(i, 16'sh7FFF, 4'(i), 4'(15 - i));
            end else begin
                push_load(i, 16'(i * 256 - 2048), 4'(i), 4'(15 - i));
            end
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        wait_idle();
        reg_write(ADDR_TERM_COUNT, 32'd16);
        push_eval(16'sh0000, 16'sh0000);
        push_eval(16'sh7FFF, 16'sh7FFF);
        push_eval(16'sh8000, 16'sh8000);
        push_eval(16'sh8000, 16'sh7FFF);
        push_eval(16'sh7FFF, 16'sh8000);

        // A count above the table size saturates; a write to an unknown register is ignored.
        wait_idle();
        reg_write(ADDR_TERM_COUNT, 32'd31);
        reg_write(ADDR_NONE, 32'd0);
        for (int k = 0; k < 6; k++) begin
            push_eval(extreme_q(), extreme_q());
        end

        for (int ph = 0; ph < 9; ph++) begin
            wait_idle();
            reg_write(ADDR_TERM_COUNT, 32'(phase_counts[ph]));
            for (int k = 0; k < 125; k++) begin
                pending_reqs.push_back(random_request());
            end
        end

        drain = 0;
        while ((pending_reqs.size() != 0 || s_valid || expected_results.size() != 0)
               && drain < 50000) begin
            @(negedge aclk);
            drain++;
        end
        repeat (TERM_SLOTS + 4) @(negedge aclk);
        if (expected_results.size() != 0) begin
            $display("%0t: %0d results expected but never received", $time,
                     expected_results.size());
            err_count++;
        end
        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== tropical_poly_argmax.f =====
design/tpa_pkg.sv
design/tpa_cell.sv
design/tropical_poly_argmax.sv
bench/testbench.sv
